[rtl/surface_orientation_score_defines.svh]
// ---------------------------------------------------------------------------
// Surface orientation score: assertion macros
// Concurrent checks on the clock/reset of the including module.
// ---------------------------------------------------------------------------
`ifndef SURFACE_ORIENTATION_SCORE_DEFINES_SVH
`define SURFACE_ORIENTATION_SCORE_DEFINES_SVH

`ifndef SYNTHESIS
// check that is masked while reset is high
`define SOS_ASSERT(lbl, prop) \
   lbl: assert property (@(posedge clock) disable iff (reset) prop) \
      else $error("surface orientation check failed");
// check that holds in every cycle, reset included
`define SOS_ASSERT_ALWAYS(lbl, prop) \
   lbl: assert property (@(posedge clock) prop) \
      else $error("surface orientation check failed");
`else
`define SOS_ASSERT(lbl, prop)
`define SOS_ASSERT_ALWAYS(lbl, prop)
`endif

`endif

[rtl/sos_pkg.sv]
// ---------------------------------------------------------------------------
// Surface orientation score package
// Shared widths, register indexes, status codes and transaction types.
// ---------------------------------------------------------------------------
package sos_pkg;

   // component format and derived product / sum widths
   localparam int CompBits  = 16;
   localparam int ProdBits  = 2 * CompBits;
   localparam int SumBits   = 2 * CompBits + 2;
   localparam int SqrtBits  = 17;
   localparam int WideBits  = 2 * SumBits + 2 * SqrtBits + 1;

   // pixel addressing
   localparam int IdxBits   = 24;
   localparam int ColBits   = 12;
   localparam int RowBits   = 12;
   localparam int WidthBits = 13;
   localparam int MaxWidth  = 4096;

   localparam int ScoreBits = 16;
   localparam int StatBits  = 2;

   // pipeline depth: one quotient bit per stage sets the length
   localparam int Latency   = IdxBits;
   localparam int PadStages = Latency - 3 - SqrtBits;

   // configuration port
   localparam int CsrIdxBits  = 3;
   localparam int CsrDataBits = 32;
   localparam logic [CsrIdxBits-1:0] CsrRefX       = 3'd0;
   localparam logic [CsrIdxBits-1:0] CsrRefY       = 3'd1;
   localparam logic [CsrIdxBits-1:0] CsrRefZ       = 3'd2;
   localparam logic [CsrIdxBits-1:0] CsrVertical   = 3'd3;
   localparam logic [CsrIdxBits-1:0] CsrMinEnergy  = 3'd4;
   localparam logic [CsrIdxBits-1:0] CsrImageWidth = 3'd5;

   // result status codes
   localparam logic [StatBits-1:0] StOk         = 2'd0;
   localparam logic [StatBits-1:0] StRefShort   = 2'd1;
   localparam logic [StatBits-1:0] StZeroNormal = 2'd2;

   typedef struct packed {
      logic [IdxBits-1:0]         pixel_index;
      logic signed [CompBits-1:0] nrm_x;
      logic signed [CompBits-1:0] nrm_y;
      logic signed [CompBits-1:0] nrm_z;
      logic                       normal_invalid;
   } req_type;

   typedef struct packed {
      logic [ColBits-1:0]   col;
      logic [RowBits-1:0]   row;
      logic [ScoreBits-1:0] score;
      logic [StatBits-1:0]  status;
   } rsp_type;

   // settled configuration seen by the datapath
   typedef struct packed {
      logic signed [CompBits-1:0] ref_x;
      logic signed [CompBits-1:0] ref_y;
      logic signed [CompBits-1:0] ref_z;
      logic                       vertical_mode;
      logic                       ref_short;
      logic [SumBits-1:0]         ref_energy;
      logic [WidthBits-1:0]       width;
   } cfg_type;

   // magnitude of a two's complement component
   function automatic logic [CompBits-1:0] comp_mag(input logic signed [CompBits-1:0] x);
      comp_mag = x[CompBits-1] ? (~x + 1'b1) : x;
   endfunction

endpackage

[rtl/surface_orientation_score.sv]
// ---------------------------------------------------------------------------
// Surface orientation score
// Absolute cosine between a per-pixel normal and a reference direction,
// with the pixel index split into column and row.
// ---------------------------------------------------------------------------
// Usage:
//   Request: drive req_data and raise start; the transaction is taken at a
//   clock edge with start high and busy low. busy never rises, so one
//   transaction can be taken every cycle. Items with normal_invalid set are
//   taken and dropped.
//   Result: rsp_strobe is high for one cycle with rsp_data, taken from the
//   output register. The receiver cannot stall; every result appears once.
//   Throughput is one item per cycle; the 24-stage index divider (one
//   quotient bit per stage) sets the latency, the 17-stage root search runs
//   alongside it.
//   Configuration: csr_wr_en, csr_index and csr_wdata write one register per
//   edge; the user writes only while no transaction is in flight, the block
//   does not enforce it. The derived reference energy settles in the cycle
//   after a write. Unknown indexes are ignored. Reset (synchronous, active
//   high) restores register defaults and clears all in-flight transactions.
// ---------------------------------------------------------------------------
`include "surface_orientation_score_defines.svh"

module surface_orientation_score (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            start,
   output logic                            busy,
   input  sos_pkg::req_type                req_data,
   output logic                            rsp_strobe,
   output sos_pkg::rsp_type                rsp_data,
   input  logic                            csr_wr_en,
   input  logic [sos_pkg::CsrIdxBits-1:0]  csr_index,
   input  logic [sos_pkg::CsrDataBits-1:0] csr_wdata
);
   import sos_pkg::*;

   // configuration registers
   logic signed [CompBits-1:0] ref_x_ff, ref_y_ff, ref_z_ff;
   logic                       vertical_ff;
   logic [CsrDataBits-1:0]     min_energy_ff;
   logic [WidthBits-1:0]       image_width_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         ref_x_ff       <= CompBits'(1 << (CompBits - 1));
         ref_y_ff       <= '0;
         ref_z_ff       <= '0;
         vertical_ff    <= 1'b0;
         min_energy_ff  <= CsrDataBits'(1074);
         image_width_ff <= WidthBits'(640);
      end else if (csr_wr_en) begin
         case (csr_index)
            CsrRefX:       ref_x_ff       <= csr_wdata[CompBits-1:0];
            CsrRefY:       ref_y_ff       <= csr_wdata[CompBits-1:0];
            CsrRefZ:       ref_z_ff       <= csr_wdata[CompBits-1:0];
            CsrVertical:   vertical_ff    <= csr_wdata[0];
            CsrMinEnergy:  min_energy_ff  <= csr_wdata;
            CsrImageWidth: image_width_ff <= csr_wdata[WidthBits-1:0];
            default: ;
         endcase
      end
   end

   // reference energy and short-reference flag, registered
   logic [CompBits-1:0] tx_mag, ty_mag, tz_mag;
   logic [ProdBits-1:0] tx_sq, ty_sq, tz_sq;
   logic [SumBits-1:0]  energy_in;
   logic [SumBits-1:0]  energy_ff;
   logic                ref_short_ff;

   assign tx_mag    = comp_mag(ref_x_ff);
   assign ty_mag    = comp_mag(ref_y_ff);
   assign tz_mag    = comp_mag(ref_z_ff);
   assign tx_sq     = tx_mag * tx_mag;
   assign ty_sq     = ty_mag * ty_mag;
   assign tz_sq     = tz_mag * tz_mag;
   assign energy_in = SumBits'(tx_sq) + SumBits'(ty_sq) + SumBits'(tz_sq);

   always_ff @(posedge clock) begin
      energy_ff    <= energy_in;
      ref_short_ff <= (energy_in == '0) || (energy_in < SumBits'(min_energy_ff));
   end

   // width clamped to 1..MaxWidth
   logic [WidthBits-1:0] width_eff;

   assign width_eff = (image_width_ff == '0) ? WidthBits'(1) :
                      (image_width_ff > WidthBits'(MaxWidth)) ? WidthBits'(MaxWidth)
                                                             : image_width_ff;

   cfg_type cfg;

   assign cfg.ref_x         = ref_x_ff;
   assign cfg.ref_y         = ref_y_ff;
   assign cfg.ref_z         = ref_z_ff;
   assign cfg.vertical_mode = vertical_ff;
   assign cfg.ref_short     = ref_short_ff;
   assign cfg.ref_energy    = energy_ff;
   assign cfg.width         = width_eff;

   // request handshake: always ready
   logic accept;

   assign busy   = 1'b0;
   assign accept = start && !busy && !req_data.normal_invalid;

   // valid bits alongside the datapath stages
   logic [Latency-1:0] vld_ff;

   always_ff @(posedge clock) begin
      if (reset) vld_ff <= '0;
      else       vld_ff <= {vld_ff[Latency-2:0], accept};
   end

   logic [ColBits-1:0]   col;
   logic [RowBits-1:0]   row;
   logic [ScoreBits-1:0] score;
   logic [StatBits-1:0]  status;

   sos_divider u_divider (
      .clock       (clock),
      .pixel_index (req_data.pixel_index),
      .width       (cfg.width),
      .col         (col),
      .row         (row)
   );

   sos_score u_score (
      .clock  (clock),
      .req    (req_data),
      .cfg    (cfg),
      .score  (score),
      .status (status)
   );

   // output register
   logic    rsp_strobe_ff;
   rsp_type rsp_data_ff;

   always_ff @(posedge clock) begin
      if (reset) rsp_strobe_ff <= 1'b0;
      else       rsp_strobe_ff <= vld_ff[Latency-1];
      rsp_data_ff <= '{col: col, row: row, score: score, status: status};
   end

   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_data   = rsp_data_ff;

   // checks
   `SOS_ASSERT(a_rsp_follows_req, rsp_strobe |-> $past(accept, Latency + 1))
   `SOS_ASSERT(a_flagged_score_zero, (rsp_strobe && rsp_data.status != StOk) |-> rsp_data.score == '0)
   `SOS_ASSERT(a_status_code, rsp_strobe |-> rsp_data.status <= StZeroNormal)
   `SOS_ASSERT_ALWAYS(a_reset_quiet, $past(reset) |-> !rsp_strobe)

endmodule

[rtl/sos_divider.sv]
// ---------------------------------------------------------------------------
// Pixel index splitter
// Restoring divider, one quotient bit per register stage: row and column.
// ---------------------------------------------------------------------------
module sos_divider (
   input  logic                          clock,
   input  logic [sos_pkg::IdxBits-1:0]   pixel_index,
   input  logic [sos_pkg::WidthBits-1:0] width,
   output logic [sos_pkg::ColBits-1:0]   col,
   output logic [sos_pkg::RowBits-1:0]   row
);
   import sos_pkg::*;

   localparam logic [IdxBits-1:0] RowLimit = IdxBits'((1 << RowBits) - 1);

   logic [WidthBits-1:0] rem_ff [Latency];
   logic [IdxBits-1:0]   quo_ff [Latency];
   logic [IdxBits-1:0]   idx_ff [Latency-1];

   for (genvar i = 0; i < Latency; i++) begin : g_stage
      logic [WidthBits-1:0] rem_prev;
      logic [IdxBits-1:0]   quo_prev;
      logic [IdxBits-1:0]   idx_prev;
      logic [WidthBits:0]   shifted;
      logic [WidthBits:0]   diff;
      logic                 take;
      logic [WidthBits-1:0] rem_in;
      logic [IdxBits-1:0]   quo_in;

      if (i == 0) begin : g_first
         assign rem_prev = '0;
         assign quo_prev = '0;
         assign idx_prev = pixel_index;
      end else begin : g_next
         assign rem_prev = rem_ff[i-1];
         assign quo_prev = quo_ff[i-1];
         assign idx_prev = idx_ff[i-1];
      end

      // trial subtract of the width from the partial remainder
      assign shifted = {rem_prev, idx_prev[Latency-1-i]};
      assign diff    = shifted - {1'b0, width};
      assign take    = (shifted >= {1'b0, width});
      assign rem_in  = take ? diff[WidthBits-1:0] : shifted[WidthBits-1:0];
      assign quo_in  = quo_prev | (take ? (IdxBits'(1) << (Latency-1-i)) : '0);

      always_ff @(posedge clock) begin
         rem_ff[i] <= rem_in;
         quo_ff[i] <= quo_in;
      end

      if (i < Latency - 1) begin : g_idx
         always_ff @(posedge clock) begin
            idx_ff[i] <= idx_prev;
         end
      end
   end

   // remainder stays below the width, row saturates
   assign col = rem_ff[Latency-1][ColBits-1:0];
   assign row = (quo_ff[Latency-1] > RowLimit) ? RowLimit[RowBits-1:0]
                                               : quo_ff[Latency-1][RowBits-1:0];

endmodule

[rtl/sos_score.sv]
// ---------------------------------------------------------------------------
// Orientation score datapath
// Products, sums, wide squares, then a bit-per-stage root search for the
// scaled cosine, padded to the common pipeline length.
// ---------------------------------------------------------------------------
module sos_score (
   input  logic                          clock,
   input  sos_pkg::req_type              req,
   input  sos_pkg::cfg_type              cfg,
   output logic [sos_pkg::ScoreBits-1:0] score,
   output logic [sos_pkg::StatBits-1:0]  status
);
   import sos_pkg::*;

   localparam logic [SqrtBits-1:0] ScoreMax = SqrtBits'((1 << ScoreBits) - 1);
   localparam logic [SqrtBits-1:0] ScoreOne = SqrtBits'(1 << ScoreBits);

   // stage 1: component products
   logic [CompBits-1:0] mag_n [3];
   logic [CompBits-1:0] mag_t [3];
   logic                neg    [3];
   logic [ProdBits-1:0] dot_ff [3];
   logic                neg_ff [3];
   logic [ProdBits-1:0] nsq_ff [3];

   assign mag_n[0] = comp_mag(req.nrm_x);
   assign mag_n[1] = comp_mag(req.nrm_y);
   assign mag_n[2] = comp_mag(req.nrm_z);
   assign mag_t[0] = comp_mag(cfg.ref_x);
   assign mag_t[1] = comp_mag(cfg.ref_y);
   assign mag_t[2] = comp_mag(cfg.ref_z);
   assign neg[0]   = req.nrm_x[CompBits-1] ^ cfg.ref_x[CompBits-1];
   assign neg[1]   = req.nrm_y[CompBits-1] ^ cfg.ref_y[CompBits-1];
   assign neg[2]   = req.nrm_z[CompBits-1] ^ cfg.ref_z[CompBits-1];

   for (genvar c = 0; c < 3; c++) begin : g_prod
      always_ff @(posedge clock) begin
         dot_ff[c] <= mag_n[c] * mag_t[c];
         nsq_ff[c] <= mag_n[c] * mag_n[c];
         neg_ff[c] <= neg[c];
      end
   end

   // stage 2: signed dot magnitude and normal energy
   logic [SumBits-1:0]  pos_sum, neg_sum, nsum_in;
   logic [SumBits-1:0]  dabs_ff, nsum_ff;
   logic [StatBits-1:0] st2_ff;

   always_comb begin
      pos_sum = '0;
      neg_sum = '0;
      nsum_in = '0;
      for (int c = 0; c < 3; c++) begin
         if (neg_ff[c]) neg_sum = neg_sum + SumBits'(dot_ff[c]);
         else           pos_sum = pos_sum + SumBits'(dot_ff[c]);
         nsum_in = nsum_in + SumBits'(nsq_ff[c]);
      end
   end

   always_ff @(posedge clock) begin
      dabs_ff <= (pos_sum >= neg_sum) ? (pos_sum - neg_sum) : (neg_sum - pos_sum);
      nsum_ff <= nsum_in;
      if (cfg.ref_short)        st2_ff <= StRefShort;
      else if (nsum_in == '0)   st2_ff <= StZeroNormal;
      else                      st2_ff <= StOk;
   end

   // stage 3: |n|^2 |t|^2 and d^2 scaled by 2^32
   logic [2*SumBits-1:0] nt_prod, dd_prod;
   logic [WideBits-1:0]  prod_ff, rhs_ff;
   logic [StatBits-1:0]  st3_ff;

   assign nt_prod = nsum_ff * cfg.ref_energy;
   assign dd_prod = dabs_ff * dabs_ff;

   always_ff @(posedge clock) begin
      prod_ff <= WideBits'(nt_prod);
      rhs_ff  <= WideBits'(dd_prod) << (2 * ScoreBits);
      st3_ff  <= st2_ff;
   end

   // root search: largest s with s^2 * prod <= rhs, MSB first
   logic [WideBits-1:0] acc_ff [SqrtBits];
   logic [WideBits-1:0] sp_ff  [SqrtBits];
   logic [WideBits-1:0] pp_ff  [SqrtBits];
   logic [WideBits-1:0] rr_ff  [SqrtBits];
   logic [SqrtBits-1:0] s_ff   [SqrtBits];
   logic [StatBits-1:0] st_ff  [SqrtBits];

   for (genvar i = 0; i < SqrtBits; i++) begin : g_root
      localparam int K = SqrtBits - 1 - i;
      logic [WideBits-1:0] acc_prev, sp_prev, pp_prev, rr_prev, trial;
      logic [SqrtBits-1:0] s_prev;
      logic [StatBits-1:0] st_prev;
      logic                take;

      if (i == 0) begin : g_first
         assign acc_prev = '0;
         assign sp_prev  = '0;
         assign pp_prev  = prod_ff;
         assign rr_prev  = rhs_ff;
         assign s_prev   = '0;
         assign st_prev  = st3_ff;
      end else begin : g_next
         assign acc_prev = acc_ff[i-1];
         assign sp_prev  = sp_ff[i-1];
         assign pp_prev  = pp_ff[i-1];
         assign rr_prev  = rr_ff[i-1];
         assign s_prev   = s_ff[i-1];
         assign st_prev  = st_ff[i-1];
      end

      // (s + 2^K)^2 P = s^2 P + 2^(K+1) s P + 2^(2K) P
      assign trial = acc_prev + (sp_prev << (K + 1)) + (pp_prev << (2 * K));
      assign take  = (trial <= rr_prev);

      always_ff @(posedge clock) begin
         acc_ff[i] <= take ? trial : acc_prev;
         sp_ff[i]  <= take ? (sp_prev + (pp_prev << K)) : sp_prev;
         s_ff[i]   <= s_prev | (take ? (SqrtBits'(1) << K) : '0);
         pp_ff[i]  <= pp_prev;
         rr_ff[i]  <= rr_prev;
         st_ff[i]  <= st_prev;
      end
   end

   // delay to line up with the index splitter
   logic [SqrtBits-1:0] sd_ff  [PadStages];
   logic [StatBits-1:0] std_ff [PadStages];

   for (genvar i = 0; i < PadStages; i++) begin : g_pad
      if (i == 0) begin : g_first
         always_ff @(posedge clock) begin
            sd_ff[i]  <= s_ff[SqrtBits-1];
            std_ff[i] <= st_ff[SqrtBits-1];
         end
      end else begin : g_next
         always_ff @(posedge clock) begin
            sd_ff[i]  <= sd_ff[i-1];
            std_ff[i] <= std_ff[i-1];
         end
      end
   end

   // mode, saturation, special cases score zero
   logic [SqrtBits-1:0] s_mode;

   assign s_mode = cfg.vertical_mode ? (ScoreOne - sd_ff[PadStages-1]) : sd_ff[PadStages-1];
   assign status = std_ff[PadStages-1];
   assign score  = (status != StOk)    ? '0 :
                   (s_mode > ScoreMax) ? ScoreMax[ScoreBits-1:0] : s_mode[ScoreBits-1:0];

endmodule

[sim/surface_orientation_score_test.sv]
// ---------------------------------------------------------------------------
// Surface orientation score testbench
// Drives pixel normals through the block under several reference, mode and
// width settings, predicts every score in exact integer arithmetic and
// checks each result against the oldest expected one.
// ---------------------------------------------------------------------------
`timescale 1ns / 100ps

module surface_orientation_score_test;
   import sos_pkg::*;

   localparam int ReqBits = $bits(req_type);

   // expected results and the register copy used to predict them
   class score_board;
      logic signed [CompBits-1:0] ref_x, ref_y, ref_z;
      logic                       vertical;
      logic [31:0]                min_energy;
      logic [WidthBits-1:0]       img_width;
      rsp_type                    pending_scores[$];
      int                         errors;

      function void reset_regs();
         ref_x = 16'sh8000;
         ref_y = '0;
         ref_z = '0;
         vertical = 1'b0;
         min_energy = 32'd1074;
         img_width = 13'd640;
      endfunction

      function void write_reg(logic [CsrIdxBits-1:0] idx, logic [31:0] val);
         case (idx)
            CsrRefX:       ref_x = val[15:0];
            CsrRefY:       ref_y = val[15:0];
            CsrRefZ:       ref_z = val[15:0];
            CsrVertical:   vertical = val[0];
            CsrMinEnergy:  min_energy = val;
            CsrImageWidth: img_width = val[12:0];
            default: ;
         endcase
      endfunction

      // column/row split plus floor(65536 |n.t| / sqrt(N T)) by search
      function rsp_type predict_score(req_type px);
         rsp_type      r;
         longint       dot, nn, tt, w, idx, rw, lo, hi, mid;
         logic [191:0] rhs, prod, lhs;
         dot = longint'(px.nrm_x) * ref_x + longint'(px.nrm_y) * ref_y
               + longint'(px.nrm_z) * ref_z;
         if (dot < 0) dot = -dot;
         nn = longint'(px.nrm_x) * px.nrm_x + longint'(px.nrm_y) * px.nrm_y
              + longint'(px.nrm_z) * px.nrm_z;
         tt = longint'(ref_x) * ref_x + longint'(ref_y) * ref_y + longint'(ref_z) * ref_z;
         w = img_width;
         if (w == 0) w = 1;
         if (w > MaxWidth) w = MaxWidth;
         idx = px.pixel_index;
         rw = idx / w;
         if (rw > 4095) rw = 4095;
         r.col = ColBits'(idx % w);
         r.row = RowBits'(rw);
         r.score = '0;
         if (tt == 0 || tt < longint'(min_energy)) begin
            r.status = StRefShort;
         end else if (nn == 0) begin
            r.status = StZeroNormal;
         end else begin
            r.status = StOk;
            rhs = (192'(dot) * 192'(dot)) << 32;
            prod = 192'(nn) * 192'(tt);
            lo = 0;
            hi = 65536;
            while (lo < hi) begin
               mid = (lo + hi + 1) / 2;
               lhs = 192'(mid * mid) * prod;
               if (lhs <= rhs) lo = mid;
               else hi = mid - 1;
            end
            if (vertical) lo = 65536 - lo;
            r.score = (lo > 65535) ? 16'hFFFF : lo[15:0];
         end
         return r;
      endfunction

      function void log_pixel(req_type px);
         if (!px.normal_invalid) pending_scores.push_back(predict_score(px));
      endfunction

      function void check_score(rsp_type got);
         rsp_type exp_r;
         if (pending_scores.size() == 0) begin
            $error("unexpected result col=%0d row=%0d", got.col, got.row);
            errors++;
            return;
         end
         exp_r = pending_scores.pop_front();
         if (got.col !== exp_r.col) begin
            $error("col: expected %0d, got %0d", exp_r.col, got.col);
            errors++;
         end
         if (got.row !== exp_r.row) begin
            $error("row: expected %0d, got %0d", exp_r.row, got.row);
            errors++;
         end
         if (got.score !== exp_r.score) begin
            $error("score: expected %0d, got %0d", exp_r.score, got.score);
            errors++;
         end
         if (got.status !== exp_r.status) begin
            $error("status: expected %0d, got %0d", exp_r.status, got.status);
            errors++;
         end
      endfunction
   endclass

   logic                   clock;
   logic                   reset;
   logic                   start;
   logic                   busy;
   req_type                req_data;
   logic                   rsp_strobe;
   rsp_type                rsp_data;
   logic                   csr_wr_en;
   logic [CsrIdxBits-1:0]  csr_index;
   logic [CsrDataBits-1:0] csr_wdata;

   score_board sb;
   int         idle_pct;

   surface_orientation_score dut (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_data(req_data), .rsp_strobe(rsp_strobe), .rsp_data(rsp_data),
      .csr_wr_en(csr_wr_en), .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   always #5 clock = ~clock;

   // monitors: transactions seen at the edge that accepts them
   always @(posedge clock) begin
      if (!reset && start && !busy) sb.log_pixel(req_data);
      if (!reset && rsp_strobe) sb.check_score(rsp_data);
   end

   task automatic write_csr(logic [CsrIdxBits-1:0] idx, logic [31:0] val);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      sb.write_reg(idx, val);
   endtask

   // drain the pipeline, then program a whole setting
   task automatic set_config(logic signed [15:0] rx, ry, rz, logic vert,
                             logic [31:0] emin, logic [12:0] w);
      int guard;
      guard = 0;
      start <= 1'b0;
      @(posedge clock);
      while (sb.pending_scores.size() != 0 && guard < 2000) begin
         @(posedge clock);
         guard++;
      end
      repeat (Latency + 6) @(posedge clock);
      write_csr(CsrRefX, 32'(rx));
      write_csr(CsrRefY, 32'(ry));
      write_csr(CsrRefZ, 32'(rz));
      write_csr(CsrVertical, 32'(vert));
      write_csr(CsrMinEnergy, emin);
      write_csr(CsrImageWidth, 32'(w));
      write_csr(3'd6, $urandom);
      repeat (3) @(posedge clock);
   endtask

   // each following cycle idles with probability idle_pct percent
   task automatic send_pixel(req_type px);
      start <= 1'b1;
      req_data <= px;
      @(posedge clock);
      while (busy) @(posedge clock);
      while ($urandom_range(99) < idle_pct) begin
         start <= 1'b0;
         req_data <= req_type'(ReqBits'({$urandom, $urandom, $urandom}));
         @(posedge clock);
      end
   endtask

   function automatic req_type make_pixel(logic [23:0] idx, logic signed [15:0] x, y, z,
                                          logic inv);
      req_type px;
      px.pixel_index = idx;
      px.nrm_x = x;
      px.nrm_y = y;
      px.nrm_z = z;
      px.normal_invalid = inv;
      return px;
   endfunction

   // mostly random normals, some parallel to the reference or zero length
   function automatic req_type random_pixel();
      req_type px;
      int      kind;
      px = req_type'(ReqBits'({$urandom, $urandom, $urandom}));
      px.normal_invalid = ($urandom_range(9) == 0);
      kind = $urandom_range(19);
      if (kind == 0) begin
         px.nrm_x = '0;
         px.nrm_y = '0;
         px.nrm_z = '0;
      end else if (kind < 3) begin
         px.nrm_x = sb.ref_x;
         px.nrm_y = sb.ref_y;
         px.nrm_z = sb.ref_z;
      end else if (kind == 3) begin
         px.nrm_x = -sb.ref_x;
         px.nrm_y = -sb.ref_y;
         px.nrm_z = -sb.ref_z;
      end else if (kind == 4) begin
         px.nrm_x = $urandom_range(1) ? 16'sh8000 : 16'sh7FFF;
         px.nrm_z = $urandom_range(1) ? 16'sh8000 : 16'sh7FFF;
      end
      if ($urandom_range(3) == 0) px.pixel_index = IdxBits'($urandom_range(20000));
      return px;
   endfunction

   task automatic random_phase(int count);
      repeat (count) send_pixel(random_pixel());
   endtask

   initial begin
      int guard;
      sb = new();
      sb.reset_regs();
      clock = 1'b0;
      reset = 1'b1;
      start = 1'b0;
      req_data = '0;
      csr_wr_en = 1'b0;
      csr_index = '0;
      csr_wdata = '0;
      idle_pct = 31;
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      repeat (3) @(posedge clock);

      // directed: reset setting, field extremes and special cases
      send_pixel(make_pixel(24'd0, 16'sh8000, 16'sh0, 16'sh0, 1'b0));
      send_pixel(make_pixel(24'hFFFFFF, 16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 1'b0));
      send_pixel(make_pixel(24'd639, 16'sh0, 16'sh0, 16'sh0, 1'b0));
      send_pixel(make_pixel(24'd640, 16'sh8000, 16'sh8000, 16'sh8000, 1'b0));
      send_pixel(make_pixel(24'd12345, 16'sh1234, 16'sh0, 16'sh0, 1'b1));
      send_pixel(make_pixel(24'd2620799, 16'sh0, 16'sh7FFF, 16'sh0, 1'b0));
      send_pixel(make_pixel(24'hAAAAAA, 16'sh5555, 16'shAAAA, 16'sh0001, 1'b0));
      set_config(16'sh0, 16'sh0, 16'sh0, 1'b1, 32'd0, 13'd0);
      send_pixel(make_pixel(24'd77, 16'sh1000, 16'sh0, 16'sh0, 1'b0));
      send_pixel(make_pixel(24'hFFFFFF, 16'sh0, 16'sh0, 16'sh0, 1'b0));
      set_config(16'sh8000, 16'sh8000, 16'sh8000, 1'b1, 32'd3221225472, 13'd8191);
      send_pixel(make_pixel(24'hFFFFFF, 16'sh8000, 16'sh8000, 16'sh8000, 1'b0));
      send_pixel(make_pixel(24'd4095, 16'sh7FFF, 16'sh8000, 16'sh0, 1'b0));
      send_pixel(make_pixel(24'd4096, 16'sh0, 16'sh0, 16'sh0, 1'b0));
      send_pixel(make_pixel(24'd9000, 16'sh0001, 16'shFFFF, 16'sh0, 1'b0));
      set_config(16'sh0010, 16'sh0, 16'sh0, 1'b0, 32'd1074, 13'd1);
      send_pixel(make_pixel(24'd5000, 16'sh7FFF, 16'sh0, 16'sh0, 1'b0));
      set_config(16'sh0030, 16'sh0, 16'sh0, 1'b0, 32'd1074, 13'd4096);
      send_pixel(make_pixel(24'hFFFFFF, 16'sh7FFF, 16'sh7FFF, 16'sh0, 1'b0));
      send_pixel(make_pixel(24'd3, 16'sh0, 16'sh0, 16'sh0, 1'b1));

      // random part over a spread of settings and idle rates
      for (int ph = 0; ph < 6; ph++) begin
         idle_pct = (ph < 2) ? 31 : (ph < 4) ? 81 : 0;
         set_config(16'($urandom), 16'($urandom), 16'($urandom), ph[0],
                    (ph == 3) ? 32'd3221225472 : $urandom_range(2000),
                    (ph == 1) ? 13'd1 : (ph == 4) ? 13'd4096
                                                  : 13'($urandom_range(1, 3000)));
         random_phase(300);
      end
      start <= 1'b0;

      // drain, then allow stragglers
      guard = 0;
      while (sb.pending_scores.size() != 0 && guard < 5000) begin
         @(posedge clock);
         guard++;
      end
      repeat (Latency + 10) @(posedge clock);
      if (sb.pending_scores.size() != 0) begin
         $error("%0d results never arrived", sb.pending_scores.size());
         sb.errors++;
      end
      if (sb.errors == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

   // run limit
   initial begin
      #50_000_000;
      $display("Verification failed");
      $finish;
   end

endmodule

[surface_orientation_score.f]
+incdir+rtl
rtl/sos_pkg.sv
rtl/sos_divider.sv
rtl/sos_score.sv
rtl/surface_orientation_score.sv
sim/surface_orientation_score_test.sv
